@@ rtl/active_weight_table_defines.svh @@
// active_weight_table_defines.svh: assertion macros for the weight table rtl
// depends on nothing; the including module must have i_clk and i_rst_n in scope
`ifndef ACTIVE_WEIGHT_TABLE_DEFINES_SVH
`define ACTIVE_WEIGHT_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AWT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/awt_pkg.sv @@
// awt_pkg: sizes, command codes and sequencer states of the weight table
// depends on nothing
package awt_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int ID_LIMIT    = 128;

    // fixed field widths of the command and result beats
    localparam int ID_W     = 8;
    localparam int WEIGHT_W = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // internal widths derived from the geometry
    localparam int SLOT_IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    // common width for unsigned compares between fields and counts
    localparam int CMP_W   = 10;

    typedef enum logic {
        CMD_SET     = 1'b0,
        CMD_DISABLE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT
    } t_state;

endpackage

@@ rtl/awt_ram.sv @@
// awt_ram: generic single write port ram with one registered read port
// depends on nothing
module awt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]                                 i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     i_raddr,
    output logic [WIDTH-1:0]                                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/active_weight_table.sv @@
// active_weight_table: top level of the ordered identifier/weight table
// depends on awt_pkg, awt_ram and active_weight_table_defines.svh
//
// Usage:
//   A command beat is taken on a rising edge with start high and busy low.
//   i_command selects set weight (look up i_shape_id, overwrite or append)
//   or disable (remove the entry at i_slot_position, close the gap).
//   Exactly one result beat follows: o_done is high for one cycle with
//   o_ok, o_slot_used and o_active_count; the receiver cannot stall it.
//   Steps: a set scans the ids from position 0 and ends on a hit (overwrite
//   the weight in place) or when the scan passes the active count (then
//   append or reject); a disable in range moves each entry above p down by
//   one place; a disable out of range is answered from idle without a scan.
//   The id scan and the shift both step one entry per cycle through the
//   table memories (one read port, registered read).
//   busy drops in the cycle o_done is shown, so a new beat may be taken then.
//   Reset empties the table (count to zero); entry contents are not cleared
//   and no clearing pass runs, so the block takes commands right after reset.
`include "active_weight_table_defines.svh"

module active_weight_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [awt_pkg::ID_W-1:0]      i_shape_id,
    input  logic [awt_pkg::WEIGHT_W-1:0]  i_weight_word,
    input  logic [awt_pkg::POS_W-1:0]     i_slot_position,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [awt_pkg::POS_W-1:0]     o_slot_used,
    output logic [awt_pkg::COUNT_W-1:0]   o_active_count
);

    import awt_pkg::*;

    // sequencer and table state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_rd_vld, n_rd_vld;

    // latched command beat
    logic [ID_W-1:0]      r_id, n_id;
    logic [WEIGHT_W-1:0]  r_weight, n_weight;
    logic [SLOT_IW-1:0]   r_pos, n_pos;

    // result beat
    logic                 r_done, n_done;
    logic                 r_ok, n_ok;
    logic [POS_W-1:0]     r_used, n_used;
    logic [COUNT_W-1:0]   r_active, n_active;

    // memory ports
    logic                 id_we, wt_we;
    logic [SLOT_IW-1:0]   mem_waddr, mem_raddr;
    logic [ID_W-1:0]      id_wdata, id_rdata;
    logic [WEIGHT_W-1:0]  wt_wdata, wt_rdata;

    // scan helpers
    logic                 issue;
    logic                 hit;
    logic                 can_append;

    awt_ram #(
        .WIDTH (ID_W),
        .DEPTH (TABLE_SLOTS)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (mem_waddr),
        .i_wdata (id_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (id_rdata)
    );

    awt_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (mem_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (wt_rdata)
    );

    assign issue      = (r_idx < r_count);
    assign hit        = r_rd_vld && (id_rdata == r_id);
    assign can_append = (CMP_W'(r_id) < CMP_W'(ID_LIMIT)) &&
                        (CMP_W'(r_count) < CMP_W'(TABLE_SLOTS));

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_id     <= n_id;
        r_weight <= n_weight;
        r_pos    <= n_pos;
        r_ok     <= n_ok;
        r_used   <= n_used;
        r_active <= n_active;
    end

    // next state, memory access and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = r_rd_vld;
        n_id      = r_id;
        n_weight  = r_weight;
        n_pos     = r_pos;
        n_done    = 1'b0;
        n_ok      = r_ok;
        n_used    = r_used;
        n_active  = r_active;
        id_we     = 1'b0;
        wt_we     = 1'b0;
        mem_waddr = r_rd_idx[SLOT_IW-1:0];
        mem_raddr = r_idx[SLOT_IW-1:0];
        id_wdata  = r_id;
        wt_wdata  = r_weight;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_id     = i_shape_id;
                    n_weight = i_weight_word;
                    n_pos    = SLOT_IW'(i_slot_position);
                    n_rd_vld = 1'b0;
                    if (i_command == CMD_SET) begin
                        n_idx   = '0;
                        n_state = ST_SEARCH;
                    end else if (CMP_W'(i_slot_position) < CMP_W'(r_count)) begin
                        n_idx   = CNT_W'(i_slot_position) + CNT_W'(1);
                        n_state = ST_SHIFT;
                    end else begin
                        // position out of range: reject at once
                        n_done   = 1'b1;
                        n_ok     = 1'b0;
                        n_used   = '0;
                        n_active = COUNT_W'(r_count);
                    end
                end
            end

            ST_SEARCH: begin
                if (hit) begin
                    // found: overwrite weight in place
                    wt_we     = 1'b1;
                    mem_waddr = r_rd_idx[SLOT_IW-1:0];
                    n_done    = 1'b1;
                    n_ok      = 1'b1;
                    n_used    = POS_W'(r_rd_idx);
                    n_active  = COUNT_W'(r_count);
                    n_rd_vld  = 1'b0;
                    n_state   = ST_IDLE;
                end else if (!issue) begin
                    // scan exhausted: append or reject
                    n_done   = 1'b1;
                    n_rd_vld = 1'b0;
                    n_state  = ST_IDLE;
                    if (can_append) begin
                        id_we     = 1'b1;
                        wt_we     = 1'b1;
                        mem_waddr = r_count[SLOT_IW-1:0];
                        n_count   = r_count + CNT_W'(1);
                        n_ok      = 1'b1;
                        n_used    = POS_W'(r_count);
                        n_active  = COUNT_W'(r_count + CNT_W'(1));
                    end else begin
                        n_ok     = 1'b0;
                        n_used   = '0;
                        n_active = COUNT_W'(r_count);
                    end
                end else begin
                    // read the next entry, compare it next cycle
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_idx = r_idx;
                    n_rd_vld = 1'b1;
                end
            end

            ST_SHIFT: begin
                // move the entry read last cycle down by one
                if (r_rd_vld) begin
                    id_we     = 1'b1;
                    wt_we     = 1'b1;
                    mem_waddr = SLOT_IW'(r_rd_idx - CNT_W'(1));
                    id_wdata  = id_rdata;
                    wt_wdata  = wt_rdata;
                end
                if (issue) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_idx = r_idx;
                    n_rd_vld = 1'b1;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_done   = 1'b1;
                    n_ok     = 1'b1;
                    n_used   = POS_W'(r_pos);
                    n_active = COUNT_W'(r_count - CNT_W'(1));
                    n_rd_vld = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_slot_used    = r_used;
    assign o_active_count = r_active;

    // checks
    `AWT_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_SLOTS),
        "valid count above table size")
    `AWT_ASSERT_SAME(a_done_idle, r_done, r_state == ST_IDLE,
        "result beat shown while sequencer busy")
    `AWT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || r_done,
        "accepted command neither working nor answered")
    `AWT_ASSERT_SAME(a_reject_slot, r_done && !r_ok, r_used == '0,
        "rejected command reports a nonzero slot")

endmodule
